FILE: rtl/urfm_pkg.sv
// Package with register offsets, ID words and the result type of the UART register model.
`timescale 1ns / 1ps

package urfm_pkg;

  localparam int unsigned AddrWidth = 16;
  localparam int unsigned DataWidth = 32;

  typedef enum logic {
    CMD_READ  = 1'b0,
    CMD_WRITE = 1'b1
  } urfm_cmd_e;

  // Register offsets.
  localparam logic [AddrWidth-1:0] ADDR_DR     = 16'h000;
  localparam logic [AddrWidth-1:0] ADDR_RSR    = 16'h004;
  localparam logic [AddrWidth-1:0] ADDR_FR     = 16'h018;
  localparam logic [AddrWidth-1:0] ADDR_ILPR   = 16'h020;
  localparam logic [AddrWidth-1:0] ADDR_IBRD   = 16'h024;
  localparam logic [AddrWidth-1:0] ADDR_FBRD   = 16'h028;
  localparam logic [AddrWidth-1:0] ADDR_LCRH   = 16'h02C;
  localparam logic [AddrWidth-1:0] ADDR_CR     = 16'h030;
  localparam logic [AddrWidth-1:0] ADDR_IFLS   = 16'h034;
  localparam logic [AddrWidth-1:0] ADDR_IMSC   = 16'h038;
  localparam logic [AddrWidth-1:0] ADDR_RIS    = 16'h03C;
  localparam logic [AddrWidth-1:0] ADDR_MIS    = 16'h040;
  localparam logic [AddrWidth-1:0] ADDR_ICR    = 16'h044;
  localparam logic [AddrWidth-1:0] ADDR_DMACR  = 16'h048;
  localparam logic [AddrWidth-1:0] ADDR_PID0   = 16'hFE0;
  localparam logic [AddrWidth-1:0] ADDR_PID1   = 16'hFE4;
  localparam logic [AddrWidth-1:0] ADDR_PID2   = 16'hFE8;
  localparam logic [AddrWidth-1:0] ADDR_PID3   = 16'hFEC;
  localparam logic [AddrWidth-1:0] ADDR_CID0   = 16'hFF0;
  localparam logic [AddrWidth-1:0] ADDR_CID1   = 16'hFF4;
  localparam logic [AddrWidth-1:0] ADDR_CID2   = 16'hFF8;
  localparam logic [AddrWidth-1:0] ADDR_CID3   = 16'hFFC;

  // Fixed peripheral and cell ID words.
  localparam logic [7:0] PID0_VAL = 8'h11;
  localparam logic [7:0] PID1_VAL = 8'h10;
  localparam logic [7:0] PID2_VAL = 8'h34;
  localparam logic [7:0] PID3_VAL = 8'h00;
  localparam logic [7:0] CID0_VAL = 8'h0D;
  localparam logic [7:0] CID1_VAL = 8'hF0;
  localparam logic [7:0] CID2_VAL = 8'h05;
  localparam logic [7:0] CID3_VAL = 8'hB1;

  // Receive-empty bit in the flag register.
  localparam int unsigned FR_RXFE_BIT = 4;

  typedef struct packed {
    logic [DataWidth-1:0] read_data;
    logic                 rx_pop;
    logic                 tx_push;
    logic [7:0]           tx_byte;
    logic                 address_error;
  } urfm_result_t;

endpackage

FILE: rtl/uart_register_file_model.sv
// Top level of the UART register model: decode, register state and the output skid stage.
`timescale 1ns / 1ps

// Channel  | Valid        | Stall        | Payload
// ---------+--------------+--------------+-------------------------------------------------
// in       | in_valid_i   | in_stall_o   | command_i, address_i, write_data_i, rx_ready_i,
//          |              |              | rx_byte_i, tx_full_i
// out      | out_valid_o  | out_stall_i  | read_data_o, rx_pop_o, tx_push_o, tx_byte_o,
//          |              |              | address_error_o
//
// The address decode and register update happen at the accepting edge, and the result is
// written at that same edge into the output register, or into the skid register when the
// output register is held.
// One request per clock is sustained while in_stall_o is low; the rate is set by the single decode stage.
// Reset clears all UART registers to zero and empties the output stages.
// A stalled result parks in a one-entry skid register, so one more request is taken
// while the output is held; in_stall_o rises only when the skid register is full.

module uart_register_file_model (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           command_i,
  input  logic [urfm_pkg::AddrWidth-1:0] address_i,
  input  logic [urfm_pkg::DataWidth-1:0] write_data_i,
  input  logic                           rx_ready_i,
  input  logic [7:0]                     rx_byte_i,
  input  logic                           tx_full_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [urfm_pkg::DataWidth-1:0] read_data_o,
  output logic                           rx_pop_o,
  output logic                           tx_push_o,
  output logic [7:0]                     tx_byte_o,
  output logic                           address_error_o
);
  import urfm_pkg::*;

  // UART register state.
  logic [11:0] data_q,       data_d;
  logic [3:0]  rsr_q,        rsr_d;
  logic [8:0]  flag_q,       flag_d;
  logic [7:0]  ilpr_q,       ilpr_d;
  logic [15:0] ibrd_q,       ibrd_d;
  logic [5:0]  fbrd_q,       fbrd_d;
  logic [7:0]  lcrh_q,       lcrh_d;
  logic [15:0] cr_q,         cr_d;
  logic [5:0]  ifls_q,       ifls_d;
  logic [10:0] imsc_q,       imsc_d;
  logic [10:0] ris_q,        ris_d;
  logic [10:0] mis_q,        mis_d;
  logic [10:0] icr_q,        icr_d;
  logic [2:0]  dmacr_q,      dmacr_d;

  // Output register and skid register.
  logic         out_valid_q, out_valid_d;
  logic         skid_valid_q, skid_valid_d;
  urfm_result_t out_q, out_d;
  urfm_result_t skid_q, skid_d;

  urfm_result_t res;
  logic         in_fire;
  logic         out_fire;

  assign in_stall_o = skid_valid_q;
  assign in_fire    = in_valid_i && !skid_valid_q;
  assign out_fire   = out_valid_q && !out_stall_i;

  // Decode of one request against the current register state. The next state is only
  // taken when the request is accepted.
  always_comb begin
    data_d  = data_q;
    rsr_d   = rsr_q;
    flag_d  = flag_q;
    ilpr_d  = ilpr_q;
    ibrd_d  = ibrd_q;
    fbrd_d  = fbrd_q;
    lcrh_d  = lcrh_q;
    cr_d    = cr_q;
    ifls_d  = ifls_q;
    imsc_d  = imsc_q;
    ris_d   = ris_q;
    mis_d   = mis_q;
    icr_d   = icr_q;
    dmacr_d = dmacr_q;

    res = '0;

    if (command_i == CMD_WRITE) begin
      // The ID words are read-only, so a write there falls into the default arm.
      case (address_i)
        ADDR_DR: begin
          data_d = write_data_i[11:0];
          if (!tx_full_i) begin
            res.tx_push = 1'b1;
            res.tx_byte = write_data_i[7:0];
          end
        end
        ADDR_RSR:   rsr_d   = write_data_i[3:0];
        ADDR_FR:    flag_d  = write_data_i[8:0];
        ADDR_ILPR:  ilpr_d  = write_data_i[7:0];
        ADDR_IBRD:  ibrd_d  = write_data_i[15:0];
        ADDR_FBRD:  fbrd_d  = write_data_i[5:0];
        ADDR_LCRH:  lcrh_d  = write_data_i[7:0];
        ADDR_CR:    cr_d    = write_data_i[15:0];
        ADDR_IFLS:  ifls_d  = write_data_i[5:0];
        ADDR_IMSC:  imsc_d  = write_data_i[10:0];
        ADDR_RIS:   ris_d   = write_data_i[10:0];
        ADDR_MIS:   mis_d   = write_data_i[10:0];
        ADDR_ICR:   icr_d   = write_data_i[10:0];
        ADDR_DMACR: dmacr_d = write_data_i[2:0];
        default:    res.address_error = 1'b1;
      endcase
    end else begin
      case (address_i)
        ADDR_DR: begin
          // Reading the data register leaves the receive side empty.
          res.read_data        = {20'd0, data_q};
          flag_d[FR_RXFE_BIT]  = 1'b1;
        end
        ADDR_FR: begin
          // Polling the flags pulls a waiting console byte into the data register.
          if (rx_ready_i) begin
            data_d[7:0]         = rx_byte_i;
            flag_d[FR_RXFE_BIT] = 1'b0;
            res.rx_pop          = 1'b1;
          end
          res.read_data = {23'd0, flag_d};
        end
        ADDR_RSR:   res.read_data = {28'd0, rsr_q};
        ADDR_ILPR:  res.read_data = {24'd0, ilpr_q};
        ADDR_IBRD:  res.read_data = {16'd0, ibrd_q};
        ADDR_FBRD:  res.read_data = {26'd0, fbrd_q};
        ADDR_LCRH:  res.read_data = {24'd0, lcrh_q};
        ADDR_CR:    res.read_data = {16'd0, cr_q};
        ADDR_IFLS:  res.read_data = {26'd0, ifls_q};
        ADDR_IMSC:  res.read_data = {21'd0, imsc_q};
        ADDR_RIS:   res.read_data = {21'd0, ris_q};
        ADDR_MIS:   res.read_data = {21'd0, mis_q};
        ADDR_ICR:   res.read_data = {21'd0, icr_q};
        ADDR_DMACR: res.read_data = {29'd0, dmacr_q};
        ADDR_PID0:  res.read_data = {24'd0, PID0_VAL};
        ADDR_PID1:  res.read_data = {24'd0, PID1_VAL};
        ADDR_PID2:  res.read_data = {24'd0, PID2_VAL};
        ADDR_PID3:  res.read_data = {24'd0, PID3_VAL};
        ADDR_CID0:  res.read_data = {24'd0, CID0_VAL};
        ADDR_CID1:  res.read_data = {24'd0, CID1_VAL};
        ADDR_CID2:  res.read_data = {24'd0, CID2_VAL};
        ADDR_CID3:  res.read_data = {24'd0, CID3_VAL};
        default:    res.address_error = 1'b1;
      endcase
    end
  end

  // Output staging. The skid register only fills when the output register is held,
  // and it always drains into the output register before new requests are taken.
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;

    if (skid_valid_q) begin
      if (out_fire) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (in_fire) begin
      if (!out_valid_q || out_fire) begin
        out_d       = res;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res;
        skid_valid_d = 1'b1;
      end
    end else if (out_fire) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q       <= '0;
      rsr_q        <= '0;
      flag_q       <= '0;
      ilpr_q       <= '0;
      ibrd_q       <= '0;
      fbrd_q       <= '0;
      lcrh_q       <= '0;
      cr_q         <= '0;
      ifls_q       <= '0;
      imsc_q       <= '0;
      ris_q        <= '0;
      mis_q        <= '0;
      icr_q        <= '0;
      dmacr_q      <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        data_q  <= data_d;
        rsr_q   <= rsr_d;
        flag_q  <= flag_d;
        ilpr_q  <= ilpr_d;
        ibrd_q  <= ibrd_d;
        fbrd_q  <= fbrd_d;
        lcrh_q  <= lcrh_d;
        cr_q    <= cr_d;
        ifls_q  <= ifls_d;
        imsc_q  <= imsc_d;
        ris_q   <= ris_d;
        mis_q   <= mis_d;
        icr_q   <= icr_d;
        dmacr_q <= dmacr_d;
      end
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // Result payload carries no reset.
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o     = out_valid_q;
  assign read_data_o     = out_q.read_data;
  assign rx_pop_o        = out_q.rx_pop;
  assign tx_push_o       = out_q.tx_push;
  assign tx_byte_o       = out_q.tx_byte;
  assign address_error_o = out_q.address_error;

endmodule
